FILE: rtl/idm_pkg.sv
// Shared types and constants of the interrupt duration monitor.
package idm_pkg;

  localparam int unsigned LogDepth       = 64;
  localparam int unsigned LogAw          = $clog2(LogDepth);
  localparam int unsigned CountW         = $clog2(LogDepth + 1);
  localparam int unsigned SoftCount      = 10;
  localparam int unsigned SoftIdxW       = (SoftCount > 1) ? $clog2(SoftCount) : 1;
  localparam int unsigned UnitShift      = 20;
  localparam int unsigned UnitsW         = 64 - UnitShift;
  localparam logic [15:0] ThresholdReset = 16'd25;

  typedef enum logic [2:0] {
    CmdHardEntry = 3'd0,
    CmdHardExit  = 3'd1,
    CmdSoftEntry = 3'd2,
    CmdSoftExit  = 3'd3,
    CmdClearLog  = 3'd4,
    CmdReadEntry = 3'd5,
    CmdHardStats = 3'd6,
    CmdSoftStats = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    CfgEnable  = 2'd0,
    CfgHardThr = 2'd1,
    CfgSoftThr = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              source;
    logic [31:0]       handler;
    logic [UnitsW-1:0] duration;
    logic [63:0]       timestamp;
  } log_entry_t;

  typedef struct packed {
    logic             we;
    logic [LogAw-1:0] addr;
    log_entry_t       data;
  } log_wr_t;

  typedef struct packed {
    logic              logged;
    logic              log_full;
    logic [UnitsW-1:0] duration_units;
    logic [CountW-1:0] log_count;
    logic              entry_valid;
    log_entry_t        entry;
    logic [31:0]       stat_count;
    logic [63:0]       stat_total;
  } result_t;

endpackage

FILE: rtl/idm_log_mem.sv
// Overrun log storage with one write port and one registered read port.
module idm_log_mem (
  input  logic                      clk_i,
  input  idm_pkg::log_wr_t          wr_i,
  input  logic                      rd_en_i,
  input  logic [idm_pkg::LogAw-1:0] rd_addr_i,
  output idm_pkg::log_entry_t       rd_data_o
);

  idm_pkg::log_entry_t mem_q [idm_pkg::LogDepth];
  idm_pkg::log_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // A read at the same edge as a write to the same entry returns the new data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.we && (wr_i.addr == rd_addr_i)) begin
        rd_q <= wr_i.data;
      end else begin
        rd_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: rtl/idm_engine.sv
// Event stage register, monitor state and the per-event update logic.
module idm_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   accept_i,
  input  logic                   advance_i,
  input  logic [2:0]             command_i,
  input  logic [63:0]            timestamp_ns_i,
  input  logic [3:0]             softirq_number_i,
  input  logic [31:0]            handler_id_i,
  input  logic                   handled_i,
  input  logic                   nested_i,
  input  logic [5:0]             entry_index_i,
  input  idm_pkg::log_entry_t    rd_data_i,
  output idm_pkg::log_wr_t       log_wr_o,
  output idm_pkg::result_t       result_o
);

  localparam int unsigned CW = idm_pkg::CountW;
  localparam int unsigned UW = idm_pkg::UnitsW;
  localparam int unsigned SC = idm_pkg::SoftCount;
  localparam int unsigned SW = idm_pkg::SoftIdxW;

  // Stage register payload.
  idm_pkg::cmd_e cmd_q;
  logic [63:0]   ts_q;
  logic [3:0]    snum_q;
  logic [31:0]   handler_q;
  logic          handled_q;
  logic          nested_q;
  logic [5:0]    idx_q;
  logic [63:0]   elapsed_q;
  logic          start_nz_q;

  // Monitor state.
  logic          enable_q;
  logic [15:0]   hard_thr_q, soft_thr_q;
  logic [63:0]   hard_start_q, hard_start_d;
  logic [63:0]   soft_start_q, soft_start_d;
  logic [31:0]   hard_runs_q, hard_runs_d;
  logic [63:0]   hard_total_q, hard_total_d;
  logic [31:0]   soft_runs_q [SC];
  logic [63:0]   soft_total_q [SC];
  logic [CW-1:0] held_q, held_d;

  logic          on;
  logic          soft_ok;
  logic [SW-1:0] sidx;
  logic [UW-1:0] units;
  logic          hard_over, soft_over;
  logic          soft_upd;
  logic          overrun;
  logic          source;
  logic          log_we;
  logic          held_full;
  logic [63:0]   hard_start_nx, soft_start_nx, start_sel;

  // The start latch seen by an event entering now is the one its predecessor
  // leaves at this same edge, so the subtraction can be done ahead of time.
  assign hard_start_nx = advance_i ? hard_start_d : hard_start_q;
  assign soft_start_nx = advance_i ? soft_start_d : soft_start_q;
  assign start_sel     = (idm_pkg::cmd_e'(command_i) == idm_pkg::CmdSoftExit) ?
                         soft_start_nx : hard_start_nx;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q      <= idm_pkg::cmd_e'(command_i);
      ts_q       <= timestamp_ns_i;
      snum_q     <= softirq_number_i;
      handler_q  <= handler_id_i;
      handled_q  <= handled_i;
      nested_q   <= nested_i;
      idx_q      <= entry_index_i;
      elapsed_q  <= timestamp_ns_i - start_sel;
      start_nz_q <= (start_sel != 64'd0);
    end
  end

  assign on        = enable_q;
  assign soft_ok   = ({1'b0, snum_q} < 5'(SC));
  assign sidx      = snum_q[SW-1:0];
  assign units     = elapsed_q[63:idm_pkg::UnitShift];
  assign held_full = (32'(held_q) >= 32'(idm_pkg::LogDepth));
  assign hard_over = (hard_thr_q != 16'd0) &&
                     ((units[UW-1:16] != '0) || (units[15:0] >= hard_thr_q));
  assign soft_over = (soft_thr_q != 16'd0) &&
                     ((units[UW-1:16] != '0) || (units[15:0] >= soft_thr_q));

  always_comb begin
    hard_start_d = hard_start_q;
    soft_start_d = soft_start_q;
    hard_runs_d  = hard_runs_q;
    hard_total_d = hard_total_q;
    held_d       = held_q;
    soft_upd     = 1'b0;
    overrun      = 1'b0;
    source       = 1'b0;
    log_we       = 1'b0;
    result_o     = '0;

    unique case (cmd_q)
      idm_pkg::CmdHardEntry: begin
        if (on && !nested_q) begin
          hard_start_d = ts_q;
        end
      end
      idm_pkg::CmdHardExit: begin
        if (on && !nested_q && handled_q && start_nz_q) begin
          hard_runs_d             = hard_runs_q + 32'd1;
          hard_total_d            = hard_total_q + elapsed_q;
          result_o.duration_units = units;
          overrun                 = hard_over;
        end
      end
      idm_pkg::CmdSoftEntry: begin
        if (on && soft_ok) begin
          soft_start_d = ts_q;
        end
      end
      idm_pkg::CmdSoftExit: begin
        if (on && soft_ok && start_nz_q) begin
          soft_upd                = 1'b1;
          result_o.duration_units = units;
          overrun                 = soft_over;
          source                  = 1'b1;
        end
      end
      idm_pkg::CmdClearLog: begin
        held_d = '0;
      end
      idm_pkg::CmdReadEntry: begin
        if (32'(idx_q) < 32'(held_q)) begin
          result_o.entry_valid = 1'b1;
          result_o.entry       = rd_data_i;
        end
      end
      idm_pkg::CmdHardStats: begin
        result_o.stat_count = hard_runs_q;
        result_o.stat_total = hard_total_q;
      end
      idm_pkg::CmdSoftStats: begin
        if (soft_ok) begin
          result_o.stat_count = soft_runs_q[sidx];
          result_o.stat_total = soft_total_q[sidx];
        end
      end
      default: ;
    endcase

    if (overrun) begin
      if (held_full) begin
        result_o.log_full = 1'b1;
      end else begin
        log_we          = 1'b1;
        result_o.logged = 1'b1;
        held_d          = held_q + CW'(1);
      end
    end
    result_o.log_count = held_d;
  end

  assign log_wr_o.we             = advance_i && log_we;
  assign log_wr_o.addr           = held_q[idm_pkg::LogAw-1:0];
  assign log_wr_o.data.source    = source;
  assign log_wr_o.data.handler   = handler_q;
  assign log_wr_o.data.duration  = units;
  assign log_wr_o.data.timestamp = ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      hard_thr_q   <= idm_pkg::ThresholdReset;
      soft_thr_q   <= idm_pkg::ThresholdReset;
      hard_start_q <= '0;
      soft_start_q <= '0;
      hard_runs_q  <= '0;
      hard_total_q <= '0;
      held_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (idm_pkg::cfg_idx_e'(cfg_index_i))
          idm_pkg::CfgEnable: begin
            enable_q <= cfg_data_i[0];
            // Turning the monitor on starts a fresh log.
            if (cfg_data_i[0] && !enable_q) begin
              held_q <= '0;
            end
          end
          idm_pkg::CfgHardThr: hard_thr_q <= cfg_data_i;
          idm_pkg::CfgSoftThr: soft_thr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (advance_i) begin
        hard_start_q <= hard_start_d;
        soft_start_q <= soft_start_d;
        hard_runs_q  <= hard_runs_d;
        hard_total_q <= hard_total_d;
        held_q       <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SC; i++) begin
        soft_runs_q[i]  <= '0;
        soft_total_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < SC; i++) begin
        if (advance_i && soft_upd && (sidx == SW'(i))) begin
          soft_runs_q[i]  <= soft_runs_q[i] + 32'd1;
          soft_total_q[i] <= soft_total_q[i] + elapsed_q;
        end
      end
    end
  end

endmodule

FILE: rtl/interrupt_duration_monitor_unit.sv
// Order: an accepted transaction is held in the stage register, moves into the result register
// when that register is free or being taken, and waits there until it is taken.
// Throughput: one event per cycle while results are taken; the stage register and the
// result register each hold one transaction, and the log memory reads at the accept edge.
// Reset: asynchronous, active low; clears monitor state, counters, the log
// count and both valid flags, and loads both thresholds with 25.
// Top level of the interrupt duration monitor.
module interrupt_duration_monitor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] timestamp_ns_i,
  input  logic [3:0]  softirq_number_i,
  input  logic [31:0] handler_id_i,
  input  logic        handled_i,
  input  logic        nested_i,
  input  logic [5:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        logged_o,
  output logic        log_full_o,
  output logic [43:0] duration_units_o,
  output logic [6:0]  log_count_o,
  output logic        entry_valid_o,
  output logic        entry_source_o,
  output logic [31:0] entry_handler_o,
  output logic [43:0] entry_duration_o,
  output logic [63:0] entry_timestamp_o,
  output logic [31:0] stat_count_o,
  output logic [63:0] stat_total_ns_o
);

  logic                s1_valid_q;
  logic                out_valid_q;
  idm_pkg::result_t    out_q;
  idm_pkg::result_t    result;
  idm_pkg::log_wr_t    log_wr;
  idm_pkg::log_entry_t rd_data;
  logic                advance;
  logic                accept;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  idm_log_mem u_log_mem (
    .clk_i     (clk_i),
    .wr_i      (log_wr),
    .rd_en_i   (accept),
    .rd_addr_i (idm_pkg::LogAw'(entry_index_i)),
    .rd_data_o (rd_data)
  );

  idm_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .accept_i         (accept),
    .advance_i        (advance),
    .command_i        (command_i),
    .timestamp_ns_i   (timestamp_ns_i),
    .softirq_number_i (softirq_number_i),
    .handler_id_i     (handler_id_i),
    .handled_i        (handled_i),
    .nested_i         (nested_i),
    .entry_index_i    (entry_index_i),
    .rd_data_i        (rd_data),
    .log_wr_o         (log_wr),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign logged_o          = out_q.logged;
  assign log_full_o        = out_q.log_full;
  assign duration_units_o  = out_q.duration_units;
  assign log_count_o       = 7'(out_q.log_count);
  assign entry_valid_o     = out_q.entry_valid;
  assign entry_source_o    = out_q.entry.source;
  assign entry_handler_o   = out_q.entry.handler;
  assign entry_duration_o  = out_q.entry.duration;
  assign entry_timestamp_o = out_q.entry.timestamp;
  assign stat_count_o      = out_q.stat_count;
  assign stat_total_ns_o   = out_q.stat_total;

endmodule

FILE: rtl/idm_checker.sv
// Port-level checks of the interrupt duration monitor and their binding.
module idm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        logged_o,
  input logic        log_full_o,
  input logic [43:0] duration_units_o,
  input logic [6:0]  log_count_o,
  input logic        entry_valid_o,
  input logic [31:0] stat_count_o
);

  // A result that waits keeps its place and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(log_count_o))
    else $error("result changed while stalled");

  // A dropped overrun only happens with every log entry in use.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && log_full_o |->
      !logged_o && (log_count_o == 7'(idm_pkg::LogDepth)))
    else $error("log full reported with free entries");

  // A new log entry leaves the log non-empty.
  a_logged_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && logged_o |-> (log_count_o != 7'd0))
    else $error("logged transaction with empty log");

  // An entry read carries no measurement or statistics.
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |->
      (duration_units_o == 44'd0) && (stat_count_o == 32'd0) && !logged_o)
    else $error("entry read mixed with other results");

endmodule

bind interrupt_duration_monitor_unit idm_checker u_idm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .logged_o         (logged_o),
  .log_full_o       (log_full_o),
  .duration_units_o (duration_units_o),
  .log_count_o      (log_count_o),
  .entry_valid_o    (entry_valid_o),
  .stat_count_o     (stat_count_o)
);
